[sv/dcb_pkg.sv]
// Package for the decimating capture buffer: field widths, operation and
// register index codes, and the records passed between front, queue and back.
// No dependencies.
package dcb_pkg;

   localparam int DEPTH       = 4096;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = 13;
   localparam int SAMPLE_W    = 32;
   localparam int X_W         = 12;
   localparam int Y_W         = 12;
   localparam int ROW_W       = 13;
   localparam int PROD_W      = Y_W + ROW_W;
   localparam int POS_W       = PROD_W + 1;
   localparam int PHASE_W     = 16;
   localparam int ACTION_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 32'sh0001_0000;  // 1.0 in Q16.16

   typedef enum logic [ACTION_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_OFFER = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY     = 2'd0,
      CSR_DECIM_FACTOR = 2'd1,
      CSR_DECIM_PHASE  = 2'd2,
      CSR_ROW_WIDTH    = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                      op;
      logic signed [SAMPLE_W-1:0]  sample;
      logic [POS_W-1:0]            pos;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]   capacity;
      logic [PHASE_W-1:0] decim_factor;
      logic [PHASE_W-1:0] decim_phase;
   } back_cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]           stored_count;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic                       index_ok;
      logic                       buffer_full;
      logic                       read_sel;
   } result_type;

endpackage

[sv/decimating_capture_buffer.sv]
// Top level of the decimating capture buffer: configuration registers and
// beat packing around dcb_front, dcb_queue and dcb_back. Uses dcb_pkg.
//
// Each request beat clears the buffer, offers a sample, reads a position or
// overwrites a position, and yields exactly one response beat carrying the
// stored count, running minimum and maximum (signed Q16.16), the read value
// and the index and full flags as they stand after that action. The block
// takes one request beat per clock and returns one response beat per clock
// when neither side stalls; a beat's response passes through the front
// register, queue slot and result register, loaded on successive edges,
// and is held in the result register while the response side holds off. The
// rate is set by the single-port sample store, which serves one append,
// overwrite or read per cycle. A position is x + y times row_width; positions
// at or beyond the stored count read as zero and ignore overwrites. The store
// needs no clearing after reset. Write configuration only while no request is
// in flight.
module decimating_capture_buffer import dcb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,   // sample[31:0], pos_x[43:32], pos_y[55:44]
   input  logic [ACTION_W-1:0]   req_tuser,   // action[1:0]
   // response side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,   // stored_count[12:0], min_value[44:13],
                                              // max_value[76:45], read_value[108:77],
                                              // buffer_full[109], zero[111:110]
   output logic                  rsp_tuser,   // index_ok
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CNT_W-1:0]           capacity_ff;
   logic [PHASE_W-1:0]         decim_factor_ff;
   logic [PHASE_W-1:0]         decim_phase_ff;
   logic [ROW_W-1:0]           row_width_ff;
   back_cfg_type               back_cfg;

   logic                       front_valid;
   logic                       front_ready;
   item_type                   front_item;
   logic                       queue_valid;
   logic                       queue_ready;
   item_type                   queue_item;
   result_type                 result;
   logic signed [SAMPLE_W-1:0] read_value;

   // Configuration registers: truncate the write data to each register's width.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff     <= CNT_W'(DEPTH);
         decim_factor_ff <= PHASE_W'(1);
         decim_phase_ff  <= '0;
         row_width_ff    <= ROW_W'(4096);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAPACITY:     capacity_ff     <= csr_wdata[CNT_W-1:0];
            CSR_DECIM_FACTOR: decim_factor_ff <= csr_wdata[PHASE_W-1:0];
            CSR_DECIM_PHASE:  decim_phase_ff  <= csr_wdata[PHASE_W-1:0];
            CSR_ROW_WIDTH:    row_width_ff    <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   assign back_cfg.capacity     = capacity_ff;
   assign back_cfg.decim_factor = decim_factor_ff;
   assign back_cfg.decim_phase  = decim_phase_ff;

   // Front: decode the action and resolve the position.
   dcb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .row_width (row_width_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_sample (req_tdata[31:0]),
      .in_pos_x  (req_tdata[43:32]),
      .in_pos_y  (req_tdata[55:44]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // Queue: lets the front keep accepting while the back holds a response.
   dcb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   // Back: advance the buffer state and register the response.
   dcb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (back_cfg),
      .in_valid       (queue_valid),
      .in_ready       (queue_ready),
      .in_item        (queue_item),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_result     (result),
      .out_read_value (read_value)
   );

   // Pack the response beat, highest field first.
   assign rsp_tdata = {2'b00,
                       result.buffer_full,
                       read_value,
                       result.max_value,
                       result.min_value,
                       result.stored_count};
   assign rsp_tuser = result.index_ok;

endmodule

[sv/dcb_front.sv]
// Front stage of the capture buffer: accepts request beats, decodes the
// action and resolves the buffer position. Uses dcb_pkg.
module dcb_front import dcb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ROW_W-1:0]           row_width,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [ACTION_W-1:0]        in_action,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  logic [X_W-1:0]             in_pos_x,
   input  logic [Y_W-1:0]             in_pos_y,
   output logic                       out_valid,
   input  logic                       out_ready,
   output item_type                   out_item
);

   logic              valid_ff;
   item_type          item_ff;
   logic [PROD_W-1:0] prod;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // position = x + y * row_width
   assign prod = PROD_W'(in_pos_y) * PROD_W'(row_width);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         item_ff.op     <= op_type'(in_action);
         item_ff.sample <= in_sample;
         item_ff.pos    <= POS_W'(prod) + POS_W'(in_pos_x);
      end
   end

endmodule

[sv/dcb_queue.sv]
// Short queue between the front and back stages of the capture buffer.
// Uses dcb_pkg for the item record and queue depth.
module dcb_queue import dcb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W:0]   fill_ff;
   logic               push;
   logic               pop;

   assign in_ready  = fill_ff != (Q_PTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      fill_ff <= fill_ff + 1'b1;
         else if (pop && !push) fill_ff <= fill_ff - 1'b1;
      end
      if (push) slot_ff[wr_ptr_ff] <= in_item;
   end

endmodule

[sv/dcb_back.sv]
// Back stage of the capture buffer: executes one item per cycle unless a held
// response stalls, on the sample store, count, phase and extremes. Uses dcb_pkg.
module dcb_back import dcb_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  back_cfg_type                cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  item_type                    in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output result_type                  out_result,
   output logic signed [SAMPLE_W-1:0]  out_read_value
);

   logic signed [SAMPLE_W-1:0] store_mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]           count_ff,  count_in;
   logic [PHASE_W-1:0]         phase_ff,  phase_in;
   logic signed [SAMPLE_W-1:0] min_ff,    min_in;
   logic signed [SAMPLE_W-1:0] max_ff,    max_in;
   logic                       rsp_valid_ff;
   result_type                 rsp_ff,    rsp_in;

   logic                       pop;
   logic [CNT_W-1:0]           eff_cap;
   logic [PHASE_W-1:0]         nq;
   logic [PHASE_W-1:0]         phase_inc;
   logic                       in_range;
   logic                       keep;
   logic                       mem_we;
   logic                       mem_re;
   logic [ADDR_W-1:0]          mem_addr;

   assign in_ready       = !rsp_valid_ff || out_ready;
   assign pop            = in_valid && in_ready;
   assign out_valid      = rsp_valid_ff;
   assign out_result     = rsp_ff;
   assign out_read_value = rsp_ff.read_sel ? rd_data_ff : '0;

   assign eff_cap   = (cfg.capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg.capacity;
   assign nq        = (cfg.decim_factor == '0) ? PHASE_W'(1) : cfg.decim_factor;
   assign phase_inc = phase_ff + 1'b1;
   assign in_range  = in_item.pos < POS_W'(count_ff);

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      keep     = 1'b0;
      rsp_in   = '0;
      unique case (in_item.op)
         OP_CLEAR: begin
            count_in = '0;
            phase_in = '0;
            min_in   = '0;
            max_in   = MAX_RESET;
         end
         OP_OFFER: begin
            // drop the sample and hold the phase once full
            if (count_ff < eff_cap) begin
               if (phase_ff == cfg.decim_phase) begin
                  keep     = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     min_in = in_item.sample;
                     max_in = in_item.sample;
                  end else begin
                     if (in_item.sample > max_ff) max_in = in_item.sample;
                     if (in_item.sample < min_ff) min_in = in_item.sample;
                  end
               end
               phase_in = (phase_inc >= nq) ? '0 : phase_inc;
            end
         end
         OP_READ: begin
            rsp_in.index_ok = in_range;
            rsp_in.read_sel = in_range;
         end
         OP_WRITE: begin
            rsp_in.index_ok = in_range;
         end
         default: ;
      endcase
      rsp_in.stored_count = count_in;
      rsp_in.min_value    = min_in;
      rsp_in.max_value    = max_in;
      rsp_in.buffer_full  = count_in >= eff_cap;
   end

   // one port: an item either appends, overwrites or reads, never two of these
   assign mem_we   = pop && (keep || (in_item.op == OP_WRITE && in_range));
   assign mem_re   = pop && in_item.op == OP_READ && in_range;
   assign mem_addr = keep ? count_ff[ADDR_W-1:0] : in_item.pos[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_addr] <= in_item.sample;
      if (mem_re) rd_data_ff <= store_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         phase_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) rsp_valid_ff <= in_valid;
         if (pop) begin
            count_ff <= count_in;
            phase_ff <= phase_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
      end
      if (pop) rsp_ff <= rsp_in;
   end

endmodule

[dv/decimating_capture_buffer_test.sv]
// Self-checking testbench for decimating_capture_buffer: queue-fed stream driver,
// response monitor and a beat-level predictor of the capture buffer.
// Depends on dcb_pkg and the decimating_capture_buffer RTL.
module decimating_capture_buffer_test;
   import dcb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;

   // One request beat as the driver presents it.
   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] smp;
      logic [X_W-1:0]             px;
      logic [Y_W-1:0]             py;
   } request_type;

   // Response beat laid out as {rsp_tuser, rsp_tdata}, lowest field last.
   typedef struct packed {
      logic                       ok;
      logic [1:0]                 pad;
      logic                       full;
      logic signed [SAMPLE_W-1:0] rd;
      logic signed [SAMPLE_W-1:0] hi;
      logic signed [SAMPLE_W-1:0] lo;
      logic [CNT_W-1:0]           count;
   } snapshot_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [111:0]          rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   decimating_capture_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the configuration registers, at their reset values.
   logic [CNT_W-1:0]   cap_cfg    = 13'd4096;
   logic [PHASE_W-1:0] factor_cfg = 16'd1;
   logic [PHASE_W-1:0] phase_cfg  = 16'd0;
   logic [ROW_W-1:0]   row_cfg    = 13'd4096;

   // Predicted buffer state. The store is only ever read below the count,
   // and every such entry has been written since the last clear.
   logic signed [SAMPLE_W-1:0] kept [DEPTH];
   logic [CNT_W-1:0]           m_count = '0;
   logic [PHASE_W-1:0]         m_phase = '0;
   logic signed [SAMPLE_W-1:0] m_lo    = '0;
   logic signed [SAMPLE_W-1:0] m_hi    = MAX_RESET;

   request_type  beat_backlog [$];
   snapshot_type awaited_status [$];
   request_type  offered;

   int issued = 0;
   int checked = 0;
   int failures = 0;
   int cycles = 0;
   int sender_odds = 0;      // percent chance per beat of a sender gap burst
   int receiver_odds = 0;    // percent chance per cycle of a receiver stall burst
   int gap_left = 0;
   int stall_left = 0;
   int long_hold_left = 0;
   bit long_hold_wanted = 1'b0;
   bit long_hold_used = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Advance the predicted state by one request and return the status the
   // block should report after it.
   function automatic snapshot_type capture_step(request_type rq);
      snapshot_type       s;
      logic [31:0]        pos;
      logic [CNT_W-1:0]   cap_eff;
      logic [PHASE_W-1:0] wrap;
      s = '0;
      pos = 32'(rq.px) + 32'(rq.py) * 32'(row_cfg);
      // capacity beyond the store saturates to its depth
      cap_eff = (cap_cfg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_cfg;
      // a zero decimation factor behaves as one
      wrap = (factor_cfg == '0) ? PHASE_W'(1) : factor_cfg;
      case (rq.op)
         OP_CLEAR: begin
            m_count = '0;
            m_phase = '0;
            m_lo = '0;
            m_hi = MAX_RESET;
         end
         OP_OFFER: begin
            // a full buffer drops the sample and freezes the phase
            if (m_count < cap_eff) begin
               if (m_phase == phase_cfg) begin
                  if (m_count == '0) begin
                     m_lo = rq.smp;
                     m_hi = rq.smp;
                  end else begin
                     if (rq.smp > m_hi) m_hi = rq.smp;
                     if (rq.smp < m_lo) m_lo = rq.smp;
                  end
                  kept[m_count[ADDR_W-1:0]] = rq.smp;
                  m_count = m_count + 1'b1;
               end
               m_phase = m_phase + 1'b1;
               if (m_phase >= wrap) m_phase = '0;
            end
         end
         OP_READ: begin
            if (pos < 32'(m_count)) begin
               s.rd = kept[pos[ADDR_W-1:0]];
               s.ok = 1'b1;
            end
         end
         default: begin
            // overwrite leaves the running extremes alone
            if (pos < 32'(m_count)) begin
               kept[pos[ADDR_W-1:0]] = rq.smp;
               s.ok = 1'b1;
            end
         end
      endcase
      s.count = m_count;
      s.lo = m_lo;
      s.hi = m_hi;
      s.full = (m_count >= cap_eff);
      return s;
   endfunction

   // Random request biased towards positions that the buffer can hold, so
   // that reads and overwrites mostly land in range.
   function automatic request_type random_request();
      request_type rq;
      int          pick;
      int          reach;
      int          target;
      pick = $urandom_range(0, 99);
      rq.op = (pick < 4) ? OP_CLEAR : (pick < 50) ? OP_OFFER : (pick < 75) ? OP_READ : OP_WRITE;
      rq.smp = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: rq.smp = 32'sh7FFF_FFFF;
            1: rq.smp = 32'sh8000_0000;
            2: rq.smp = '0;
            default: rq.smp = -32'sd1;
         endcase
      end
      rq.px = X_W'($urandom);
      rq.py = Y_W'($urandom);
      if ($urandom_range(0, 6) != 0) begin
         reach = (cap_cfg > 13'd64) ? 66 : int'(cap_cfg) + 2;
         target = $urandom_range(0, reach);
         if ($urandom_range(0, 1) == 1) begin
            rq.py = Y_W'(target / int'(row_cfg));
            rq.px = X_W'(target % int'(row_cfg));
         end else begin
            rq.py = '0;
            rq.px = X_W'(target);
         end
      end
      return rq;
   endfunction

   task automatic queue_beat(input op_type op, input logic [31:0] smp,
                             input logic [X_W-1:0] px, input logic [Y_W-1:0] py);
      request_type rq;
      rq.op = op;
      rq.smp = smp;
      rq.px = px;
      rq.py = py;
      beat_backlog = {beat_backlog, rq};
      issued++;
   endtask

   // Hold until every issued beat has come back, then let the pipe settle.
   task automatic drain_pipeline();
      while (checked < issued) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CAPACITY:     cap_cfg = val[CNT_W-1:0];
         CSR_DECIM_FACTOR: factor_cfg = val;
         CSR_DECIM_PHASE:  phase_cfg = val;
         default:          row_cfg = val[ROW_W-1:0];
      endcase
   endtask

   // Reconfigure while idle, then load a batch of random requests.
   task automatic run_phase(input logic [CNT_W-1:0] cap, input logic [PHASE_W-1:0] fac,
                            input logic [PHASE_W-1:0] ph, input logic [ROW_W-1:0] rw,
                            input int beats);
      drain_pipeline();
      write_reg(CSR_CAPACITY, CSR_DATA_W'(cap));
      write_reg(CSR_DECIM_FACTOR, fac);
      write_reg(CSR_DECIM_PHASE, ph);
      write_reg(CSR_ROW_WIDTH, CSR_DATA_W'(rw));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      repeat (beats) beat_backlog = {beat_backlog, random_request()};
      issued += beats;
   endtask

   // Request driver: predict each beat at the edge that accepts it, then
   // either idle for a burst or present the next beat from the backlog.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_status = {awaited_status, capture_step(offered)};
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (sender_odds > 0 && $urandom_range(1, 100) <= sender_odds) begin
               gap_left <= $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else if (beat_backlog.size() > 0) begin
               offered = beat_backlog.pop_front();
               req_tdata <= {offered.py, offered.px, offered.smp};
               req_tuser <= offered.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready: one long hold-off on request, otherwise random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_wanted && !long_hold_used) begin
         long_hold_used <= 1'b1;
         long_hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_odds > 0 && $urandom_range(1, 100) <= receiver_odds) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response monitor: compare each accepted beat with the oldest prediction.
   always @(posedge clock) begin
      snapshot_type got;
      snapshot_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (awaited_status.size() == 0) begin
            failures++;
            if (failures <= SHOW_LIMIT)
               $display("unexpected response beat: count=%0d rd=%h", got.count, got.rd);
         end else begin
            want = awaited_status.pop_front();
            checked++;
            if (got !== want) begin
               failures++;
               if (failures <= SHOW_LIMIT) begin
                  $write("response %0d mismatch: count %0d/%0d min %h/%h max %h/%h ",
                         checked, want.count, got.count, want.lo, got.lo, want.hi, got.hi);
                  $display("rd %h/%h ok %b/%b full %b/%b pad %b/%b (expected/actual)",
                           want.rd, got.rd, want.ok, got.ok, want.full, got.full,
                           want.pad, got.pad);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [PHASE_W-1:0] fac;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed checks under the reset configuration.
      sender_odds = 10;
      receiver_odds = 10;
      queue_beat(OP_READ, 32'h0, 12'd0, 12'd0);            // empty buffer reads zero
      queue_beat(OP_WRITE, 32'h1234_5678, 12'd0, 12'd0);   // overwrite on empty is dropped
      queue_beat(OP_OFFER, 32'h7FFF_FFFF, 12'd0, 12'd0);   // first sample sets both extremes
      queue_beat(OP_OFFER, 32'h8000_0000, 12'd0, 12'd0);
      queue_beat(OP_OFFER, 32'h0000_0000, 12'd0, 12'd0);
      queue_beat(OP_OFFER, 32'hFFFF_FFFF, 12'd0, 12'd0);
      queue_beat(OP_OFFER, 32'h0001_0000, 12'd0, 12'd0);
      queue_beat(OP_READ, 32'h0, 12'd0, 12'd0);
      queue_beat(OP_READ, 32'h0, 12'd4, 12'd0);
      queue_beat(OP_READ, 32'h0, 12'd5, 12'd0);            // first position past the count
      queue_beat(OP_READ, 32'h0, 12'd4095, 12'd4095);
      queue_beat(OP_WRITE, 32'h4000_0000, 12'd2, 12'd0);   // extremes must not move
      queue_beat(OP_READ, 32'h0, 12'd2, 12'd0);
      queue_beat(OP_WRITE, 32'hDEAD_BEEF, 12'd4095, 12'd0);
      queue_beat(OP_WRITE, 32'hDEAD_BEEF, 12'd0, 12'd4095);
      queue_beat(OP_READ, 32'h0, 12'd1, 12'd0);
      queue_beat(OP_CLEAR, 32'hFFFF_FFFF, 12'd4095, 12'd4095);
      queue_beat(OP_READ, 32'h0, 12'd0, 12'd0);            // cleared buffer reads zero
      queue_beat(OP_OFFER, 32'hFFFF_0000, 12'd0, 12'd0);   // first after clear replaces 0 and 1.0
      queue_beat(OP_OFFER, 32'hFFFF_0000, 12'd0, 12'd0);
      queue_beat(OP_READ, 32'h0, 12'd1, 12'd0);
      queue_beat(OP_WRITE, 32'h0000_0001, 12'd1, 12'd0);
      queue_beat(OP_READ, 32'h0, 12'd1, 12'd0);

      // Zero capacity reports full at once; zero factor acts as one.
      sender_odds = 20;
      receiver_odds = 20;
      run_phase(13'd0, 16'd0, 16'd0, 13'd1, 30);
      // Capacity above the depth saturates; two-dimensional positions.
      run_phase(13'd8191, 16'd3, 16'd2, 13'd7, 150);
      // Phase beyond the factor: nothing is ever kept.
      run_phase(13'd1, 16'd65535, 16'd65535, 13'd4096, 30);
      // Single-entry buffer fills on the first offer.
      sender_odds = 0;
      receiver_odds = 0;
      run_phase(13'd1, 16'd1, 16'd0, 13'd1, 40);

      // Long receiver hold-off while the sender keeps streaming: the block
      // must back up and stall its request side.
      sender_odds = 3;
      receiver_odds = 10;
      long_hold_wanted = 1'b1;
      run_phase(13'd24, 16'd2, 16'd1, 13'd5, 200);
      sender_odds = 15;
      run_phase(13'd4096, 16'd65535, 16'd0, 13'd8191, 60);

      repeat (4) begin
         sender_odds = $urandom_range(0, 30);
         receiver_odds = $urandom_range(0, 30);
         fac = PHASE_W'($urandom_range(1, 4));
         run_phase(($urandom_range(0, 4) == 0) ? 13'($urandom_range(1, 8))
                                               : 13'($urandom_range(8, 64)),
                   fac,
                   ($urandom_range(0, 4) == 0) ? 16'($urandom_range(fac, fac + 2))
                                               : 16'($urandom_range(0, fac - 1)),
                   ($urandom_range(0, 2) == 0) ? 13'($urandom_range(1, 8191))
                                               : 13'($urandom_range(1, 16)),
                   200);
      end

      // Closing stretch at full rate on both sides.
      sender_odds = 0;
      receiver_odds = 0;
      run_phase(13'd40, 16'd1, 16'd0, 13'd6, 200);

      drain_pipeline();
      repeat (10) @(negedge clock);
      if (failures == 0 && awaited_status.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
